@@ rtl/wall_distance_pose_correct_macros.svh @@
// Assertion macros for the wall distance pose correction block.
// Used by the top level only; no other dependencies.
`ifndef WALL_DISTANCE_POSE_CORRECT_MACROS_SVH
`define WALL_DISTANCE_POSE_CORRECT_MACROS_SVH

// same-cycle implication, disabled in reset
`define WDPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WDPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks across reset
`define WDPC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wdpc_pkg.sv @@
// Shared constants, types and helpers for the wall distance pose correction.
// No dependencies.
package wdpc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int ANGLE_BITS = 16;

    localparam int POS_W  = 16;
    localparam int HEAD_W = 16;
    localparam int MM_W   = 14;
    localparam int CFG_W  = 15;
    localparam int ADDR_W = 2;

    localparam logic [ADDR_W-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MAX_DIST    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_BACK_OFFSET = 2'd2;
    localparam logic [ADDR_W-1:0] REG_LEFT_OFFSET = 2'd3;

    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 15'd18432;
    localparam logic [CFG_W-1:0] MAX_DIST_RST    = 15'd15360;
    localparam logic [CFG_W-1:0] BACK_OFFSET_RST = 15'd1792;
    localparam logic [CFG_W-1:0] LEFT_OFFSET_RST = 15'd1792;

    // 32-bit turn angles
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [31:0] ANGLE_MASK   = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // mm to position units: floor((mm * 20 * 2^FRAC_BITS + 254) / 508)
    localparam longint CONV_MUL = 64'd20 << FRAC_BITS;
    localparam longint NUM_MAX  = ((64'd1 << MM_W) - 1) * CONV_MUL + 254;
    localparam int     NUM_W    = $clog2(NUM_MAX + 1);
    localparam longint DIV_C    = 508;
    localparam int     RCP_K    = NUM_W + 9;
    localparam longint RCP      = (64'd1 << RCP_K) / DIV_C;
    localparam int     RCP_W    = $clog2(RCP + 1);
    localparam longint D_MAX    = NUM_MAX / DIV_C;
    localparam int     D_W      = $clog2(D_MAX + 1);

    // CORDIC, Q30 results
    localparam int CORDIC_STEPS = 20;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458908, 33'sd85004757, 33'sd42667331,
        33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
        33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
        33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304
    };

    // lane registers p0 .. p(LANE_LAT-1)
    localparam int LANE_LAT = CORDIC_STEPS + 3;

    typedef struct packed {
        logic                    ok;
        logic                    use_y;
        logic signed [POS_W-1:0] val;
    } lane_res_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } pose_t;

endpackage

@@ rtl/wdpc_lane.sv @@
// One sensor lane: mm conversion, pipelined CORDIC, wall pick and coordinate update.
// Depends on wdpc_pkg.
module wdpc_lane (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [31:0]                     ray,
    input  logic [wdpc_pkg::MM_W-1:0]       mm,
    input  logic                            use_in,
    input  logic [wdpc_pkg::CFG_W-1:0]      half_width,
    input  logic [wdpc_pkg::CFG_W-1:0]      max_dist,
    input  logic signed [wdpc_pkg::CFG_W-1:0] offset,
    output wdpc_pkg::lane_res_t             res
);
    import wdpc_pkg::*;

    localparam int DS_W  = D_W + 2;
    localparam int PR_W  = DS_W + XY_W;
    localparam int RN_W  = PR_W - 30;
    localparam int RES_W = RN_W + 2;

    typedef struct packed {
        logic           flip;
        logic           use_y;
        logic           pos;
        logic           use_en;
        logic [D_W-1:0] d;
    } side_t;

    logic signed [XY_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STEPS];
    side_t                  side_reg [0:CORDIC_STEPS];

    logic [NUM_W-1:0]         num_reg, num1_reg;
    logic [NUM_W+RCP_W-1:0]   mq_reg;

    // entry: wall choice from the exact angle, CORDIC folded to +-90 deg
    logic [31:0] sh, r2;
    logic        flip, exact, use_y, pos;
    logic [NUM_W-1:0] num;

    always_comb begin
        sh    = ray + EIGHTH_TURN;
        exact = (sh[29:0] == 30'd0);
        if (exact) begin
            use_y = 1'b0;
            pos   = (sh == QUARTER_TURN) || (sh == HALF_TURN);
        end else begin
            use_y = ~sh[30];
            pos   = ~sh[31];
        end
        flip = (ray + QUARTER_TURN) >> 31 != 32'd0;
        r2   = flip ? ray - HALF_TURN : ray;
        num  = NUM_W'(mm * CONV_MUL + 254);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= Z_W'(signed'(r2));
            side_reg[0] <= {flip, use_y, pos, use_in, D_W'(0)};
            num_reg     <= num;
            mq_reg      <= num_reg * RCP_W'(RCP);
            num1_reg    <= num_reg;
        end
    end

    // reciprocal estimate is exact or one short
    logic [D_W-1:0]   q_est, d_fix;
    logic [NUM_W-1:0] rem;
    always_comb begin
        q_est = D_W'(mq_reg >> RCP_K);
        rem   = num1_reg - NUM_W'(q_est * DIV_C);
        d_fix = (rem >= NUM_W'(DIV_C)) ? q_est + D_W'(1) : q_est;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TURN[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TURN[i];
                end
            end
        end
        if (i == 1) begin : g_dfix
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i+1] <= {side_reg[i].flip, side_reg[i].use_y, side_reg[i].pos,
                                      side_reg[i].use_en, d_fix};
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end
    end

    // product stage
    side_t                   sd;
    logic signed [XY_W-1:0]  comp;
    logic signed [DS_W-1:0]  dsum;
    logic signed [PR_W-1:0]  prod_reg;
    logic                    ok_reg, use_y_reg, pos_reg;
    logic [CFG_W-1:0]        fh_reg;

    always_comb begin
        sd   = side_reg[CORDIC_STEPS];
        comp = sd.use_y ? x_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        if (sd.flip) begin
            comp = -comp;
        end
        dsum = signed'({2'b00, sd.d}) + DS_W'(offset);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= PR_W'(dsum) * PR_W'(comp);
            ok_reg    <= sd.use_en && (sd.d != '0) && (sd.d < D_W'(max_dist));
            use_y_reg <= sd.use_y;
            pos_reg   <= sd.pos;
            fh_reg    <= half_width;
        end
    end

    // rounding, wall and saturation
    logic signed [PR_W-1:0]  prnd;
    logic signed [RES_W-1:0] wall, upd;
    logic signed [POS_W-1:0] sat;

    always_comb begin
        prnd = prod_reg + (PR_W'(1) <<< 29);
        wall = pos_reg ? signed'(RES_W'(fh_reg)) : -signed'(RES_W'(fh_reg));
        upd  = wall - RES_W'(prnd >>> 30);
        if (upd > RES_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (upd < -RES_W'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = POS_W'(upd);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res <= {ok_reg, use_y_reg, sat};
        end
    end

endmodule

@@ rtl/wall_distance_pose_correct.sv @@
// Top level of the wall distance pose correction: streaming ports, registers, pose pipeline.
// Depends on wdpc_pkg, wdpc_lane and wall_distance_pose_correct_macros.svh.
`include "wall_distance_pose_correct_macros.svh"

// Corrects a robot pose from back and left wall-distance sensors. One beat is taken
// every clock while the output side accepts; each beat passes through 23 lane stages
// (the 20-step CORDIC plus conversion and multiply), then through the output register.
// Both lanes run in parallel, left overriding back on the same coordinate.
// A stall on m_tready holds the whole pipeline. The user must write registers through
// cfg_we/cfg_addr/cfg_wdata only while no beat is in flight; the block does not enforce it.
module wall_distance_pose_correct (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [wdpc_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [wdpc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pose_x[15:0] pose_y[31:16] heading[47:32] back_mm[61:48] left_mm[75:62]
    // use_back[76] use_left[77] zero[79:78]
    input  logic [79:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // new_x[15:0] new_y[31:16] back_applied[32] left_applied[33] zero[39:34]
    output logic [39:0]                      m_tdata
);
    import wdpc_pkg::*;

    logic [CFG_W-1:0] half_width_reg, max_dist_reg, back_off_reg, left_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RST;
            max_dist_reg   <= MAX_DIST_RST;
            back_off_reg   <= BACK_OFFSET_RST;
            left_off_reg   <= LEFT_OFFSET_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HALF_WIDTH:  half_width_reg <= cfg_wdata;
                REG_MAX_DIST:    max_dist_reg   <= cfg_wdata;
                REG_BACK_OFFSET: back_off_reg   <= cfg_wdata;
                REG_LEFT_OFFSET: left_off_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;

    logic [31:0] head, ray_back, ray_left;
    always_comb begin
        head     = {s_tdata[47:32], 16'd0} & ANGLE_MASK;
        ray_back = head + HALF_TURN;
        ray_left = head - QUARTER_TURN;
    end

    lane_res_t res_b, res_l;

    wdpc_lane u_back (
        .aclk       (aclk),
        .en         (en),
        .ray        (ray_back),
        .mm         (s_tdata[61:48]),
        .use_in     (s_tdata[76]),
        .half_width (half_width_reg),
        .max_dist   (max_dist_reg),
        .offset     (back_off_reg),
        .res        (res_b)
    );

    wdpc_lane u_left (
        .aclk       (aclk),
        .en         (en),
        .ray        (ray_left),
        .mm         (s_tdata[75:62]),
        .use_in     (s_tdata[77]),
        .half_width (half_width_reg),
        .max_dist   (max_dist_reg),
        .offset     (left_off_reg),
        .res        (res_l)
    );

    // pose and valid travel alongside the lanes
    pose_t pose_reg [0:LANE_LAT-1];
    logic  vld_reg  [0:LANE_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            pose_reg[0] <= {s_tdata[15:0], s_tdata[31:16]};
            for (int k = 1; k < LANE_LAT; k++) begin
                pose_reg[k] <= pose_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LANE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // left wins over back on a shared coordinate
    logic signed [POS_W-1:0] nx, ny;
    always_comb begin
        nx = pose_reg[LANE_LAT-1].x;
        ny = pose_reg[LANE_LAT-1].y;
        if (res_l.ok && !res_l.use_y) begin
            nx = res_l.val;
        end else if (res_b.ok && !res_b.use_y) begin
            nx = res_b.val;
        end
        if (res_l.ok && res_l.use_y) begin
            ny = res_l.val;
        end else if (res_b.ok && res_b.use_y) begin
            ny = res_b.val;
        end
    end

    logic [39:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {6'd0, res_l.ok, res_b.ok, ny, nx};
        end
    end
    assign m_tdata = m_data_reg;

    logic last_vld;
    assign last_vld = vld_reg[LANE_LAT-1];

    `WDPC_ASSERT_NXT_ALWAYS(a_rst_clears_out, aclk, !aresetn, !m_valid_reg, "valid after reset")
    `WDPC_ASSERT_NXT(a_last_stage_lands, aclk, aresetn, last_vld && en, m_valid_reg, "beat lost")
    `WDPC_ASSERT_IMP(a_back_ok_range, aclk, aresetn, last_vld && res_b.ok, max_dist_reg != '0, "back ok")

endmodule

@@ sim/tb_wall_distance_pose_correct.sv @@
// Testbench for wall_distance_pose_correct: random and directed poses and sensor readings,
// checked against an in-bench fixed-point predictor. Depends on wdpc_pkg and the RTL top.
module tb_wall_distance_pose_correct;
    timeunit 1ns;
    timeprecision 1ps;
    import wdpc_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               back_applied;
        logic               left_applied;
    } pose_fix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    wall_distance_pose_correct dut (.*);

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 40;

    longint     half_width_m, max_dist_m, back_off_m, left_off_m;
    pose_fix_t  expected_poses[$];
    int         mismatches = 0;
    int         unexpected = 0;
    int         beats_sent = 0;
    int         beats_checked = 0;
    longint     cycles = 0;
    bit         mask_stall = 1'b0;
    longint     atan_tab[20] = '{536870912, 316933406, 167458908, 85004757, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304};

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_wall_distance_pose_correct: done, errors");
            $finish;
        end
    end

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // >>> on longint is arithmetic, i.e. floor
    function automatic void rot(input logic [31:0] r, output longint c, output longint s);
        bit flip;
        longint x, y, z, dx, dy;
        flip = 1'(((r + QUARTER_TURN) >> 31) & 32'd1);
        if (flip) r = r - HALF_TURN;
        z = r[31] ? longint'(r) - 64'sd4294967296 : longint'(r);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void wall_fix(longint d, longint off, logic [31:0] r,
                                     inout longint nx, inout longint ny);
        logic [31:0] sh;
        logic [1:0]  sector;
        bit          use_y, positive;
        longint      c, s, comp, wall;
        sh = r + EIGHTH_TURN;
        sector = sh[31:30];
        if (sh[29:0] == 0) begin
            use_y = 0;
            positive = (sh == QUARTER_TURN || sh == HALF_TURN);
        end else begin
            use_y = (sector == 0 || sector == 2);
            positive = (sector == 0 || sector == 1);
        end
        rot(r, c, s);
        comp = use_y ? c : s;
        wall = positive ? half_width_m : -half_width_m;
        wall -= ((d + off) * comp + (64'sd1 <<< 29)) >>> 30;
        if (use_y) ny = sat16(wall);
        else nx = sat16(wall);
    endfunction

    function automatic pose_fix_t predict_pose(logic [79:0] d);
        longint nx, ny, db, dl;
        logic [31:0] head;
        pose_fix_t p;
        nx = longint'($signed(d[15:0]));
        ny = longint'($signed(d[31:16]));
        head = {d[47:32], 16'h0} & ANGLE_MASK;
        db = (longint'(d[61:48]) * (20 << FRAC_BITS) + 254) / 508;
        dl = (longint'(d[75:62]) * (20 << FRAC_BITS) + 254) / 508;
        p.back_applied = d[76] && db > 0 && db < max_dist_m;
        p.left_applied = d[77] && dl > 0 && dl < max_dist_m;
        if (p.back_applied) wall_fix(db, back_off_m, head + HALF_TURN, nx, ny);
        if (p.left_applied) wall_fix(dl, left_off_m, head - QUARTER_TURN, nx, ny);
        p.x = nx[15:0];
        p.y = ny[15:0];
        return p;
    endfunction

    // result side: random stall per beat, compare with oldest expectation
    initial begin
        int gap;
        pose_fix_t got, want;
        @(posedge aclk iff aresetn);
        forever begin
            gap = mask_stall ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
            got.x = m_tdata[15:0];
            got.y = m_tdata[31:16];
            got.back_applied = m_tdata[32];
            got.left_applied = m_tdata[33];
            beats_checked++;
            if (expected_poses.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_poses.pop_front();
                if (got !== want || m_tdata[39:34] !== 6'd0) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp x=%0d y=%0d b=%b l=%b got x=%0d y=%0d b=%b l=%b",
                            want.x, want.y, want.back_applied, want.left_applied,
                            got.x, got.y, got.back_applied, got.left_applied);
                end
            end
        end
    end

    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                             logic [15:0] hd, logic [13:0] bmm, logic [13:0] lmm,
                             logic ub, logic ul);
        logic [79:0] d;
        int gap;
        d = {2'b00, ul, ub, lmm, bmm, hd, py, px};
        gap = mask_stall ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk iff s_tready);
        expected_poses.push_back(predict_pose(d));
        beats_sent++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        end_burst();
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HALF_WIDTH:  half_width_m = val;
            REG_MAX_DIST:    max_dist_m = val;
            REG_BACK_OFFSET: back_off_m = longint'($signed(val));
            REG_LEFT_OFFSET: left_off_m = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_random(int n, bit wide_mm);
        logic [13:0] bmm, lmm;
        for (int i = 0; i < n; i++) begin
            bmm = wide_mm ? 14'($urandom) : 14'($urandom_range(0, 400));
            lmm = wide_mm ? 14'($urandom) : 14'($urandom_range(0, 400));
            if ($urandom_range(0, 3) == 0) bmm = 14'($urandom_range(0, 2));
            send_pose(16'($urandom), 16'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 7) << 13)
                                                  : 16'($urandom),
                      bmm, lmm, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
        end
    endtask

    // poses at the axes, the diagonals, extreme fields and mm at boundaries
    task automatic test_directed();
        send_pose(16'sh7FFF, 16'sh8000, 16'h0000, 14'd300, 14'd300, 1'b1, 1'b1);
        send_pose(16'sh8000, 16'sh7FFF, 16'h4000, 14'd1000, 14'd50, 1'b1, 1'b1);
        send_pose(16'sd0, 16'sd0, 16'h8000, 14'd0, 14'd1, 1'b1, 1'b1);
        send_pose(16'sd0, 16'sd0, 16'hC000, 14'h3FFF, 14'd9999, 1'b1, 1'b1);
        send_pose(16'sd100, -16'sd100, 16'h2000, 14'd500, 14'd500, 1'b1, 1'b1);
        send_pose(16'sd100, -16'sd100, 16'h6000, 14'd500, 14'd500, 1'b1, 1'b0);
        send_pose(-16'sd5, 16'sd5, 16'hA000, 14'd500, 14'd500, 1'b0, 1'b1);
        send_pose(-16'sd5, 16'sd5, 16'hE000, 14'd500, 14'd500, 1'b1, 1'b1);
        send_pose(16'sd7, 16'sd7, 16'hFFFF, 14'd1524, 14'd1523, 1'b1, 1'b1);
        send_pose(16'sd7, 16'sd7, 16'h0001, 14'd2, 14'd3, 1'b1, 1'b1);
        send_pose(16'sd1, 16'sd2, 16'h1FFF, 14'd700, 14'd700, 1'b0, 1'b0);
        send_pose(16'sd1, 16'sd2, 16'h2001, 14'h2AAA, 14'h1555, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_reset_config();
        send_random(100, 1'b0);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_HALF_WIDTH, 15'h7FFF);
        write_reg(REG_MAX_DIST, 15'h7FFF);
        write_reg(REG_BACK_OFFSET, 15'h4000);
        write_reg(REG_LEFT_OFFSET, 15'h3FFF);
        send_random(90, 1'b1);
        wait_idle();
        write_reg(REG_HALF_WIDTH, 15'd0);
        write_reg(REG_MAX_DIST, 15'd0);
        write_reg(REG_BACK_OFFSET, 15'h6000);
        write_reg(REG_LEFT_OFFSET, 15'h2000);
        send_random(30, 1'b0);
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_HALF_WIDTH, 15'($urandom));
            write_reg(REG_MAX_DIST, 15'($urandom_range(0, 16000)));
            write_reg(REG_BACK_OFFSET, 15'($urandom));
            write_reg(REG_LEFT_OFFSET, 15'($urandom));
            send_random(70, k[0]);
            wait_idle();
        end
    endtask

    // back-to-back beats with no stalls on either side
    task automatic test_full_rate();
        write_reg(REG_HALF_WIDTH, HALF_WIDTH_RST);
        write_reg(REG_MAX_DIST, MAX_DIST_RST);
        write_reg(REG_BACK_OFFSET, BACK_OFFSET_RST);
        write_reg(REG_LEFT_OFFSET, LEFT_OFFSET_RST);
        mask_stall = 1'b1;
        send_random(120, 1'b0);
        mask_stall = 1'b0;
        wait_idle();
    endtask

    initial begin
        half_width_m = HALF_WIDTH_RST;
        max_dist_m = MAX_DIST_RST;
        back_off_m = longint'($signed(BACK_OFFSET_RST));
        left_off_m = longint'($signed(LEFT_OFFSET_RST));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_reset_config();
        test_config_sweep();
        test_full_rate();
        $display("sent %0d pose beats, checked %0d results across reset, extreme and",
                 beats_sent, beats_checked);
        $display("random register settings; %0d mismatches, %0d unexpected beats",
                 mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && expected_poses.size() == 0)
            $display("tb_wall_distance_pose_correct: done, clean");
        else
            $display("tb_wall_distance_pose_correct: done, errors");
        $finish;
    end
endmodule
